>>> rtl/pointer_motion_acceleration_unit_macros.svh
// Assertion macros for the pointer motion acceleration unit checker
`ifndef POINTER_MOTION_ACCELERATION_UNIT_MACROS_SVH
`define POINTER_MOTION_ACCELERATION_UNIT_MACROS_SVH

// Clocked assertion, held off while reset is low
`define PMACC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define PMACC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pmacc_pkg.sv
// Shared types and constants of the pointer motion acceleration unit
`default_nettype none

package pmacc_pkg;

  // Fixed field widths
  localparam int TIME_W     = 48;
  localparam int OUT_W      = 20;
  localparam int GAIN_W     = 16;
  localparam int FULL_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int CNT_W      = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SPD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPD   = 2'd3;

  // Iteration counts and arithmetic constants
  localparam int SQRT_STEPS = 30;
  localparam int VDIV_STEPS = 50;
  localparam int PDIV_STEPS = 16;
  localparam int E_MIN      = 1000;
  localparam int E_MAX      = 50000;
  localparam int SPEED_CAP  = 8192;
  localparam int US_PER_S   = 1000000;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQUARE,
    OP_SQRT_STEP,
    OP_VMUL,
    OP_DIV_STEP,
    OP_PCHK,
    OP_PTAKE,
    OP_P2,
    OP_SMUL,
    OP_GAIN,
    OP_MUL_AXIS,
    OP_FIN_AXIS,
    OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic axis_y;
  } dp_cmd_t;

  typedef struct packed {
    logic need_pdiv;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/pmacc_ctrl.sv
// Sequencer of the pointer motion acceleration unit
`default_nettype none

module pmacc_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  output pmacc_pkg::dp_cmd_t    cmd,
  input  pmacc_pkg::dp_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQUARE, S_SQRT, S_VMUL, S_VDIV, S_PCHK, S_PDIV, S_PTAKE,
    S_P2, S_SMUL, S_GAIN, S_MULX, S_FINX, S_MULY, S_FINY, S_DONE
  } state_t;

  state_t                        state_r;
  logic [pmacc_pkg::CNT_W-1:0]   cnt_r;
  logic                          out_valid_r;
  logic                          slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Decode the datapath command from the state
  always_comb begin
    cmd.op     = pmacc_pkg::OP_NONE;
    cmd.axis_y = 1'b0;
    unique case (state_r)
      S_IDLE:   cmd.op = in_valid ? pmacc_pkg::OP_LOAD : pmacc_pkg::OP_NONE;
      S_SQUARE: cmd.op = pmacc_pkg::OP_SQUARE;
      S_SQRT:   cmd.op = pmacc_pkg::OP_SQRT_STEP;
      S_VMUL:   cmd.op = pmacc_pkg::OP_VMUL;
      S_VDIV:   cmd.op = pmacc_pkg::OP_DIV_STEP;
      S_PCHK:   cmd.op = pmacc_pkg::OP_PCHK;
      S_PDIV:   cmd.op = pmacc_pkg::OP_DIV_STEP;
      S_PTAKE:  cmd.op = pmacc_pkg::OP_PTAKE;
      S_P2:     cmd.op = pmacc_pkg::OP_P2;
      S_SMUL:   cmd.op = pmacc_pkg::OP_SMUL;
      S_GAIN:   cmd.op = pmacc_pkg::OP_GAIN;
      S_MULX:   cmd.op = pmacc_pkg::OP_MUL_AXIS;
      S_FINX:   cmd.op = pmacc_pkg::OP_FIN_AXIS;
      S_MULY: begin
        cmd.op     = pmacc_pkg::OP_MUL_AXIS;
        cmd.axis_y = 1'b1;
      end
      S_FINY: begin
        cmd.op     = pmacc_pkg::OP_FIN_AXIS;
        cmd.axis_y = 1'b1;
      end
      S_DONE:   cmd.op = slot_free ? pmacc_pkg::OP_PUBLISH : pmacc_pkg::OP_NONE;
      default:  cmd.op = pmacc_pkg::OP_NONE;
    endcase
  end

  // Advance the sequence, count iterations, hold the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_SQUARE;
        S_SQUARE: begin
          cnt_r   <= pmacc_pkg::CNT_W'(pmacc_pkg::SQRT_STEPS - 1);
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (cnt_r == '0) state_r <= S_VMUL;
          else cnt_r <= cnt_r - 1'b1;
        end
        S_VMUL: begin
          cnt_r   <= pmacc_pkg::CNT_W'(pmacc_pkg::VDIV_STEPS - 1);
          state_r <= S_VDIV;
        end
        S_VDIV: begin
          if (cnt_r == '0) state_r <= S_PCHK;
          else cnt_r <= cnt_r - 1'b1;
        end
        S_PCHK: begin
          cnt_r   <= pmacc_pkg::CNT_W'(pmacc_pkg::PDIV_STEPS - 1);
          state_r <= status.need_pdiv ? S_PDIV : S_P2;
        end
        S_PDIV: begin
          if (cnt_r == '0) state_r <= S_PTAKE;
          else cnt_r <= cnt_r - 1'b1;
        end
        S_PTAKE: state_r <= S_P2;
        S_P2:    state_r <= S_SMUL;
        S_SMUL:  state_r <= S_GAIN;
        S_GAIN:  state_r <= S_MULX;
        S_MULX:  state_r <= S_FINX;
        S_FINX:  state_r <= S_MULY;
        S_MULY:  state_r <= S_FINY;
        S_FINY:  state_r <= S_DONE;
        S_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/pmacc_dp.sv
// Datapath of the pointer motion acceleration unit: registers, root, divider, gain
`default_nettype none

module pmacc_dp #(
  parameter int DELTA_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     cfg_wr_en,
  input  wire  [pmacc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [pmacc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  wire  signed [DELTA_WIDTH-1:0]           in_raw_dx,
  input  wire  signed [DELTA_WIDTH-1:0]           in_raw_dy,
  input  wire  [pmacc_pkg::TIME_W-1:0]            in_time_now_us,
  input  pmacc_pkg::dp_cmd_t                      cmd,
  output pmacc_pkg::dp_status_t                   status,
  output logic signed [pmacc_pkg::OUT_W-1:0]      out_move_x,
  output logic signed [pmacc_pkg::OUT_W-1:0]      out_move_y
);

  localparam int G       = GAIN_FRAC_BITS;
  localparam int MIN_RST = ((55 << G) + 50) / 100;
  localparam int MAX_RST = 2 << G;
  localparam int CW      = (DELTA_WIDTH + 1 > 14) ? DELTA_WIDTH + 1 : 14;
  localparam int TW      = DELTA_WIDTH + 19;
  localparam int FW      = G + 1;
  localparam int QMW     = TW - G;
  localparam int QW      = (QMW > 21) ? QMW : 21;

  // Configuration
  logic [15:0] min_gain_r;
  logic [16:0] max_gain_r;
  logic [15:0] start_r;
  logic [16:0] full_r;

  // Item state
  logic [pmacc_pkg::TIME_W-1:0] last_time_r;
  logic                         seen_r;
  logic signed [FW-1:0]         frac_x_r, frac_y_r;
  logic signed [DELTA_WIDTH-1:0] dx_r, dy_r;
  logic [15:0]                  e_r;

  // Root, divider and gain pipeline
  logic [59:0] rad_r;
  logic [32:0] srem_r;
  logic [29:0] root_r;
  logic [49:0] q_r;
  logic [16:0] rem_r;
  logic [16:0] divisor_r;
  logic [16:0] p_r, p2_r, s_r, gain_r;
  logic signed [TW-1:0] t_r;
  logic signed [pmacc_pkg::OUT_W-1:0] mx_r, my_r;

  function automatic logic [13:0] cap_abs(input logic signed [DELTA_WIDTH-1:0] d);
    logic signed [DELTA_WIDTH:0] ext;
    logic [DELTA_WIDTH:0]        a;
    logic [CW-1:0]               w;
    ext = {d[DELTA_WIDTH-1], d};
    a   = ext[DELTA_WIDTH] ? DELTA_WIDTH'(0) - ext : ext;
    w   = CW'(a);
    return (w > CW'(pmacc_pkg::SPEED_CAP)) ? 14'(pmacc_pkg::SPEED_CAP) : 14'(w);
  endfunction

  // Effective settings
  logic [15:0] gmin;
  logic [16:0] gmax, den;
  assign gmin = (min_gain_r == '0) ? 16'(MIN_RST) : min_gain_r;
  assign gmax = (max_gain_r < {1'b0, gmin}) ? {1'b0, gmin} : max_gain_r;
  assign den  = (full_r <= {1'b0, start_r}) ? 17'd1 : full_r - {1'b0, start_r};

  // Elapsed time, clamped
  logic [pmacc_pkg::TIME_W-1:0] tdiff;
  logic [15:0]                  e_nxt;
  assign tdiff = in_time_now_us - last_time_r;
  always_comb begin
    priority if (!seen_r)                     e_nxt = 16'(pmacc_pkg::E_MAX);
    else if (in_time_now_us < last_time_r)    e_nxt = 16'(pmacc_pkg::E_MIN);
    else if (tdiff < 48'(pmacc_pkg::E_MIN))   e_nxt = 16'(pmacc_pkg::E_MIN);
    else if (tdiff > 48'(pmacc_pkg::E_MAX))   e_nxt = 16'(pmacc_pkg::E_MAX);
    else                                      e_nxt = tdiff[15:0];
  end

  // Squared length
  logic [13:0] ax, ay;
  logic [27:0] sumsq;
  assign ax    = cap_abs(dx_r);
  assign ay    = cap_abs(dy_r);
  assign sumsq = {14'b0, ax} * {14'b0, ax} + {14'b0, ay} * {14'b0, ay};

  // One root digit
  logic [32:0] srem2, trial;
  logic        sge;
  assign srem2 = {srem_r[30:0], rad_r[59:58]};
  assign trial = {1'b0, root_r, 2'b01};
  assign sge   = srem2 >= trial;

  // One quotient bit
  logic [17:0] dt;
  logic        dge;
  assign dt  = {rem_r, q_r[49]};
  assign dge = dt >= {1'b0, divisor_r};

  // Progress check
  logic [39:0] vspd, vbase, vdiff, vlim;
  logic        above;
  assign vspd  = q_r[39:0];
  assign vbase = {8'b0, start_r, 16'b0};
  assign vdiff = vspd - vbase;
  assign vlim  = {7'b0, den, 16'b0};
  assign above = vspd > vbase;
  assign status.need_pdiv = above && (vdiff < vlim);

  // Curve products
  logic [33:0] p2_prod;
  logic [17:0] sfac;
  logic [34:0] s_prod;
  logic [16:0] dg;
  logic [33:0] g_prod;
  assign p2_prod = {17'b0, p_r} * {17'b0, p_r};
  assign sfac    = 18'(3 * 65536) - {p_r, 1'b0};
  assign s_prod  = {18'b0, p2_r} * {17'b0, sfac};
  assign dg      = gmax - {1'b0, gmin};
  assign g_prod  = {17'b0, dg} * {17'b0, s_r};

  // Axis multiply and split
  logic signed [DELTA_WIDTH-1:0] d_sel;
  logic signed [FW-1:0]          f_sel;
  logic signed [TW-1:0]          t_nxt;
  logic                          tneg;
  logic [TW-1:0]                 tmag;
  logic [QW-1:0]                 qm;
  logic signed [FW-1:0]          frac_nxt;
  logic signed [pmacc_pkg::OUT_W-1:0] mv_nxt;
  assign d_sel = cmd.axis_y ? dy_r : dx_r;
  assign f_sel = cmd.axis_y ? frac_y_r : frac_x_r;
  assign t_nxt = TW'(d_sel) * TW'($signed({1'b0, gain_r})) + TW'(f_sel);
  assign tneg  = t_r[TW-1];
  assign tmag  = tneg ? TW'(0) - t_r : t_r;
  assign qm    = QW'(tmag >> G);
  always_comb begin
    frac_nxt = FW'({1'b0, tmag[G-1:0]});
    if (tneg) frac_nxt = FW'(0) - frac_nxt;
    if (tneg) begin
      mv_nxt = (qm > QW'(524288)) ? 20'sh80000 : 20'(QW'(0) - qm);
    end else begin
      mv_nxt = (qm > QW'(524287)) ? 20'sh7FFFF : qm[19:0];
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gain_r <= 16'(MIN_RST);
      max_gain_r <= 17'(MAX_RST);
      start_r    <= 16'd120;
      full_r     <= 17'd900;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pmacc_pkg::CFG_MIN_GAIN:  min_gain_r <= cfg_wdata[15:0];
        pmacc_pkg::CFG_MAX_GAIN:  max_gain_r <= {1'b0, cfg_wdata[15:0]};
        pmacc_pkg::CFG_START_SPD: start_r    <= cfg_wdata[15:0];
        pmacc_pkg::CFG_FULL_SPD:  full_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold timestamp and remainders across items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      seen_r      <= 1'b0;
      frac_x_r    <= '0;
      frac_y_r    <= '0;
    end else begin
      if (cmd.op == pmacc_pkg::OP_LOAD) begin
        last_time_r <= in_time_now_us;
        seen_r      <= 1'b1;
      end
      if (cmd.op == pmacc_pkg::OP_FIN_AXIS) begin
        if (cmd.axis_y) frac_y_r <= frac_nxt;
        else frac_x_r <= frac_nxt;
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pmacc_pkg::OP_LOAD: begin
        dx_r <= in_raw_dx;
        dy_r <= in_raw_dy;
        e_r  <= e_nxt;
      end
      pmacc_pkg::OP_SQUARE: begin
        rad_r  <= {sumsq, 32'b0};
        srem_r <= '0;
        root_r <= '0;
      end
      pmacc_pkg::OP_SQRT_STEP: begin
        srem_r <= sge ? srem2 - trial : srem2;
        root_r <= {root_r[28:0], sge};
        rad_r  <= {rad_r[57:0], 2'b00};
      end
      pmacc_pkg::OP_VMUL: begin
        q_r       <= {20'b0, root_r} * 50'(pmacc_pkg::US_PER_S);
        rem_r     <= '0;
        divisor_r <= {1'b0, e_r};
      end
      pmacc_pkg::OP_DIV_STEP: begin
        rem_r <= dge ? 17'(dt - {1'b0, divisor_r}) : dt[16:0];
        q_r   <= {q_r[48:0], dge};
      end
      pmacc_pkg::OP_PCHK: begin
        if (status.need_pdiv) begin
          rem_r     <= vdiff[32:16];
          q_r       <= {vdiff[15:0], 34'b0};
          divisor_r <= den;
        end else begin
          p_r <= above ? 17'd65536 : 17'd0;
        end
      end
      pmacc_pkg::OP_PTAKE:    p_r    <= {1'b0, q_r[15:0]};
      pmacc_pkg::OP_P2:       p2_r   <= p2_prod[32:16];
      pmacc_pkg::OP_SMUL:     s_r    <= s_prod[32:16];
      pmacc_pkg::OP_GAIN:     gain_r <= {1'b0, gmin} + g_prod[32:16];
      pmacc_pkg::OP_MUL_AXIS: t_r    <= t_nxt;
      pmacc_pkg::OP_FIN_AXIS: begin
        if (cmd.axis_y) my_r <= mv_nxt;
        else mx_r <= mv_nxt;
      end
      pmacc_pkg::OP_PUBLISH: begin
        out_move_x <= mx_r;
        out_move_y <= my_r;
      end
      pmacc_pkg::OP_NONE: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/pointer_motion_acceleration_unit.sv
// Top level of the pointer motion acceleration unit
// Usage:
//   Input beats carry a raw delta pair and a microsecond timestamp on a
//   valid/ready channel; result beats carry the accelerated move pair.
//   Settings go in through cfg_wr_en/cfg_index/cfg_wdata, one register per
//   write, taken at once, while no beat is in flight.
//   One beat is worked at a time: a new beat is taken only once the last
//   one has been written to the output register. The 30-step square root
//   and the 50-step speed divide run one bit per cycle, plus 16 steps of
//   the same shift-subtract divider for the progress ratio when the speed
//   lies between the start and full speeds.
//   in_ready is high whenever the sequencer is idle, also while a finished
//   beat waits on out_ready; a stalled result holds in the output register
//   and the next finished beat waits until that one is taken.
//   Reset (rst_n low, synchronous) restores the default settings, clears
//   the timestamp history and the fractional remainders and empties the
//   output register.
`default_nettype none

module pointer_motion_acceleration_unit #(
  parameter int DELTA_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_wr_en,
  input  wire  [pmacc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [pmacc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  signed [DELTA_WIDTH-1:0]       in_raw_dx,
  input  wire  signed [DELTA_WIDTH-1:0]       in_raw_dy,
  input  wire  [pmacc_pkg::TIME_W-1:0]        in_time_now_us,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [pmacc_pkg::OUT_W-1:0]  out_move_x,
  output logic signed [pmacc_pkg::OUT_W-1:0]  out_move_y
);

  pmacc_pkg::dp_cmd_t    cmd;
  pmacc_pkg::dp_status_t status;

  pmacc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  pmacc_dp #(
    .DELTA_WIDTH    (DELTA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_raw_dx      (in_raw_dx),
    .in_raw_dy      (in_raw_dy),
    .in_time_now_us (in_time_now_us),
    .cmd            (cmd),
    .status         (status),
    .out_move_x     (out_move_x),
    .out_move_y     (out_move_y)
  );

endmodule

`default_nettype wire

>>> rtl/pmacc_chk.sv
// Port checker of the pointer motion acceleration unit, bound to the top level
`default_nettype none
`include "pointer_motion_acceleration_unit_macros.svh"

module pmacc_chk (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire [pmacc_pkg::OUT_W-1:0]        out_move_x,
  input wire [pmacc_pkg::OUT_W-1:0]        out_move_y
);

  // Reset empties the output and leaves the block ready
  `PMACC_ASSERT_RST(a_reset_idle, !rst_n |=> (!out_valid && in_ready), "reset state wrong")

  // An accepted beat keeps the block busy in the next cycle
  `PMACC_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")

  // No result appears right after an accept with an empty output
  `PMACC_ASSERT(a_no_early_result, (in_valid && in_ready && !out_valid) |=> !out_valid, "early result")

  // A stalled result holds
  `PMACC_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_move_x) && $stable(out_move_y)), "stalled result changed")

endmodule

bind pointer_motion_acceleration_unit pmacc_chk u_pmacc_chk (.*);

`default_nettype wire
